>>> rtl/pal_pkg.sv
// shared constants, operation codes and control structs for the positional array list
package pal_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  localparam int OP_W  = 3;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH         = 3'd0;
  localparam logic [OP_W-1:0] OP_POP          = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE       = 3'd3;
  localparam logic [OP_W-1:0] OP_GET          = 3'd4;
  localparam logic [OP_W-1:0] OP_RANGE_DELETE = 3'd5;

  localparam logic [1:0] LEN_HOLD = 2'd0;
  localparam logic [1:0] LEN_INC  = 2'd1;
  localparam logic [1:0] LEN_DEC  = 2'd2;
  localparam logic [1:0] LEN_SUB  = 2'd3;

  typedef struct packed {
    logic       capture;    // latch request and set up the shift
    logic       shift;      // one read step of the shift
    logic       put_value;  // write the request value
    logic       get_read;   // read the entry at position
    logic [1:0] len_op;
    logic       post;       // load the output register
  } pal_cmd_t;

  typedef struct packed {
    logic            err;
    logic [OP_W-1:0] op;
    logic            left_zero;
    logic            last_step;
    logic            out_busy;
  } pal_sts_t;

endpackage

>>> rtl/pal_req_if.sv
// request channel: operation, position, value and count
interface pal_req_if;
  logic                                valid;
  logic                                ready;
  logic        [pal_pkg::OP_W-1:0]     operation;
  logic        [pal_pkg::POS_W-1:0]    position;
  logic signed [pal_pkg::VAL_W-1:0]    value;
  logic        [pal_pkg::CNT_W-1:0]    count;

  modport source (output valid, output operation, output position, output value,
                  output count, input ready);
  modport sink (input valid, input operation, input position, input value,
                input count, output ready);
endinterface

>>> rtl/pal_rsp_if.sv
// response channel: status, read value and length
interface pal_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [pal_pkg::VAL_W-1:0]    read_value;
  logic        [pal_pkg::LEN_W-1:0]    length;

  modport source (output valid, output status, output read_value, output length,
                  input ready);
  modport sink (input valid, input status, input read_value, input length,
                output ready);
endinterface

>>> rtl/positional_array_list_top.sv
// top level of the positional array list
//
//   channel | dir | payload
//   req     | in  | operation, position, value, count
//   rsp     | out | status, read_value, length
//
// push, pop, get and any failed request: accept, then DECODE, then POST loads the result.
// insert, delete and range delete moving k entries: DECODE, then SHIFT for each entry, FLUSH,
// FINISH and POST (DECODE, FINISH and POST when k is zero), one entry per cycle through the
// memory's single write port; k is at most CAPACITY.
// one item is in work at a time; it may be accepted while the last result waits.
// a result waits in its register while rsp is stalled; reset empties the list.
module positional_array_list_top (
  input logic       clk,
  input logic       rst,
  pal_req_if.sink   req,
  pal_rsp_if.source rsp
);
  import pal_pkg::*;

  pal_cmd_t cmd;
  pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pal_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_operation  (req.operation),
    .req_position   (req.position),
    .req_value      (req.value),
    .req_count      (req.count),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value),
    .rsp_length     (rsp.length)
  );

endmodule

>>> rtl/pal_datapath.sv
// list storage, length register, shift address counters and output register
module pal_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  pal_pkg::pal_cmd_t                cmd,
  output pal_pkg::pal_sts_t                sts,
  input  logic        [pal_pkg::OP_W-1:0]  req_operation,
  input  logic        [pal_pkg::POS_W-1:0] req_position,
  input  logic signed [pal_pkg::VAL_W-1:0] req_value,
  input  logic        [pal_pkg::CNT_W-1:0] req_count,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic                             rsp_status,
  output logic signed [pal_pkg::VAL_W-1:0] rsp_read_value,
  output logic        [pal_pkg::LEN_W-1:0] rsp_length
);
  import pal_pkg::*;

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  mem_q;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  val;
  logic [CNT_W-1:0]  ecnt;
  logic              err;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  left;
  logic              wr_pend;

  logic              err_next;
  logic [CNT_W-1:0]  ecnt_in;
  logic [POS_W:0]    span;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [VAL_W-1:0]  mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  // delete is a range delete of one entry
  assign ecnt_in = (req_operation == OP_DELETE) ? CNT_W'(1) : req_count;
  assign span    = {1'b0, req_position} + (POS_W + 1)'(ecnt_in);

  always_comb begin
    unique case (req_operation)
      OP_PUSH:         err_next = (len >= LEN_W'(CAPACITY));
      OP_POP:          err_next = (len == '0);
      OP_INSERT:       err_next = (len >= LEN_W'(CAPACITY)) || (req_position > len);
      OP_GET:          err_next = (req_position >= len);
      OP_DELETE,
      OP_RANGE_DELETE: err_next = (span > (POS_W + 1)'(len));
      default:         err_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= req_operation;
      pos  <= req_position;
      val  <= req_value;
      ecnt <= ecnt_in;
      err  <= err_next;
      if (req_operation == OP_INSERT) begin
        rd_addr <= ADDR_W'(len - LEN_W'(1));
        left    <= len - LEN_W'(req_position);
      end else begin
        rd_addr <= ADDR_W'(span);
        left    <= LEN_W'((POS_W + 1)'(len) - span);
      end
    end else if (cmd.shift) begin
      // insert walks down, delete walks up; each write goes out in the cycle after its read
      if (op == OP_INSERT) begin
        rd_addr <= rd_addr - ADDR_W'(1);
        wr_addr <= rd_addr + ADDR_W'(1);
      end else begin
        rd_addr <= rd_addr + ADDR_W'(1);
        wr_addr <= rd_addr - ADDR_W'(ecnt);
      end
      left <= left - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr;
    mem_wd = mem_q;
    if (wr_pend) begin
      mem_we = 1'b1;
    end else if (cmd.put_value) begin
      mem_we = 1'b1;
      mem_wa = (op == OP_PUSH) ? ADDR_W'(len) : ADDR_W'(pos);
      mem_wd = val;
    end
    mem_re = cmd.shift || cmd.get_read;
    mem_ra = cmd.shift ? rd_addr : ADDR_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_comb begin
    unique case (cmd.len_op)
      LEN_INC: len_next = len + LEN_W'(1);
      LEN_DEC: len_next = len - LEN_W'(1);
      LEN_SUB: len_next = len - LEN_W'(ecnt);
      default: len_next = len;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.post) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      rsp_status     <= err;
      rsp_read_value <= (op == OP_GET && !err) ? mem_q : '0;
      rsp_length     <= len;
    end
  end

  assign sts.err       = err;
  assign sts.op        = op;
  assign sts.left_zero = (left == '0);
  assign sts.last_step = (left == LEN_W'(1));
  assign sts.out_busy  = rsp_valid && !rsp_ready;

`ifndef NO_ASSERTIONS
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

  a_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_pend && cmd.put_value))
    else $error("shift write collides with value write");

  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> !(rsp_valid && !rsp_ready))
    else $error("result loaded over an untaken item");

  a_post_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> rsp_valid)
    else $error("posted result not shown");
`endif

endmodule

>>> rtl/pal_ctrl.sv
// sequencer: decode, shift loop, length update and result post
module pal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pal_pkg::pal_sts_t sts,
  output pal_pkg::pal_cmd_t cmd
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_POST   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.len_op = LEN_HOLD;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_POST;
        if (!sts.err) begin
          unique case (sts.op)
            OP_PUSH: begin
              cmd.put_value = 1'b1;
              cmd.len_op    = LEN_INC;
            end
            OP_POP: cmd.len_op = LEN_DEC;
            OP_GET: cmd.get_read = 1'b1;
            OP_INSERT, OP_DELETE, OP_RANGE_DELETE: begin
              state_next = sts.left_zero ? S_FINISH : S_SHIFT;
            end
            default: state_next = S_POST;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.last_step) begin
          state_next = S_FLUSH;
        end
      end
      // last trailing write goes out here
      S_FLUSH: state_next = S_FINISH;
      S_FINISH: begin
        if (sts.op == OP_INSERT) begin
          cmd.put_value = 1'b1;
          cmd.len_op    = LEN_INC;
        end else begin
          cmd.len_op = LEN_SUB;
        end
        state_next = S_POST;
      end
      S_POST: begin
        if (!sts.out_busy) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_shift_left: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> !sts.left_zero)
    else $error("shift step with nothing left");

  a_shift_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> !sts.err)
    else $error("shift on a failed request");

  a_flush_next: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |=> state == S_FINISH)
    else $error("flush not followed by finish");
`endif

endmodule

>>> test/positional_array_list_checker.sv
// checker for the positional array list: predicts every result and compares it
module positional_array_list_checker (
  input  logic clk,
  input  logic rst,
  pal_req_if   req,
  pal_rsp_if   rsp,
  output int   fails,
  output int   pending,
  output int   shadow_len
);
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  typedef struct {
    logic                    status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  logic signed [VAL_W-1:0] list_contents [$];
  list_result_t            expected_results [$];
  int                      fail_count = 0;
  int                      waiting_count = 0;

  assign fails   = fail_count;
  assign pending = waiting_count;

  // applies one request to the shadow list and returns the answer it should give
  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val,
                                                 input logic [CNT_W-1:0] cnt);
    list_result_t r;
    int n;
    int p;
    int c;
    n = list_contents.size();
    p = pos;
    c = cnt;
    r.status     = 1'b0;
    r.read_value = '0;
    case (op)
      OP_PUSH: begin
        if (n >= CAPACITY) r.status = 1'b1;
        else list_contents.insert(n, val);
      end
      OP_POP: begin
        if (n == 0) r.status = 1'b1;
        else list_contents.delete(n - 1);
      end
      OP_INSERT: begin
        if (n >= CAPACITY || p > n) r.status = 1'b1;
        else list_contents.insert(p, val);
      end
      OP_DELETE: begin
        if (p >= n) r.status = 1'b1;
        else list_contents.delete(p);
      end
      OP_GET: begin
        if (p >= n) r.status = 1'b1;
        else r.read_value = list_contents[p];
      end
      OP_RANGE_DELETE: begin
        if (p + c > n) r.status = 1'b1;
        else repeat (c) list_contents.delete(p);
      end
      default: r.status = 1'b1;
    endcase
    r.length = LEN_W'(list_contents.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_contents.delete();
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no request outstanding: status %0d length %0d",
                 rsp.status, rsp.length);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp.length);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(req.operation, req.position, req.value, req.count);
        expected_results.insert(expected_results.size(), want);
      end
    end
    waiting_count = expected_results.size();
    shadow_len <= list_contents.size();
  end

endmodule

>>> test/positional_array_list_top_tb.sv
// testbench top for the positional array list: stimulus, handshake pacing and verdict
module positional_array_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int MAX_GAP      = 18;
  localparam int RANDOM_ITEMS = 500;
  localparam int SHRINK_ABOVE = 40;
  localparam int RUN_LIMIT    = 10_000_000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   shadow_len;
  bit   req_calm = 1'b0;
  bit   rsp_calm = 1'b0;

  pal_req_if req ();
  pal_rsp_if rsp ();

  positional_array_list_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  positional_array_list_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fails      (fails),
    .pending    (pending),
    .shadow_len (shadow_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // now and then switch between paced and back-to-back stretches
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                              input logic signed [VAL_W-1:0] val, input int cnt);
    int gap;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.position  <= pos[POS_W-1:0];
    req.value     <= val;
    req.count     <= cnt[CNT_W-1:0];
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic run_directed();
    // empty list corners
    send_request(OP_POP, 0, 32'sd0, 0);
    send_request(OP_GET, 0, 32'sd0, 0);
    send_request(OP_DELETE, 0, 32'sd0, 0);
    send_request(OP_RANGE_DELETE, 0, 32'sd0, 0);
    send_request(OP_RANGE_DELETE, 0, 32'sd0, 1);
    send_request(OP_INSERT, 1, 32'sd5, 0);
    send_request(OP_INSERT, 0, 32'sh8000_0000, 0);
    send_request(OP_PUSH, 0, 32'sh7fff_ffff, 0);
    send_request(OP_PUSH, 0, 32'sd0, 0);
    send_request(OP_PUSH, 0, -32'sd1, 0);
    send_request(OP_INSERT, 2, 32'sh5a5a_5a5a, 0);
    // insert at the current length appends
    send_request(OP_INSERT, 5, 32'sh0000_a5a5, 0);
    send_request(OP_GET, 0, 32'sd0, 0);
    send_request(OP_GET, 5, 32'sd0, 0);
    send_request(OP_GET, 6, 32'sd0, 0);
    send_request(OP_DELETE, 1, 32'sd0, 0);
    send_request(OP_RANGE_DELETE, 1, 32'sd0, 2);
    send_request(OP_RANGE_DELETE, 2047, 32'sd0, 2047);
    send_request(OP_GET, 2047, 32'sd0, 0);
    send_request(OP_SPARE_6, 2047, -32'sd1, 2047);
    send_request(OP_SPARE_7, 0, 32'sd0, 0);
    send_request(OP_POP, 0, 32'sd0, 0);
    // zero count at the end of the list is fine
    send_request(OP_RANGE_DELETE, 2, 32'sd0, 0);
    send_request(OP_RANGE_DELETE, 0, 32'sd0, 2);
  endtask

  task automatic run_full_list();
    for (int k = 0; k < CAPACITY; k++)
      send_request(OP_PUSH, $urandom_range(0, 2047), $urandom, $urandom_range(0, 2047));
    send_request(OP_PUSH, 0, 32'sd7, 0);
    send_request(OP_INSERT, 0, 32'sd7, 0);
    send_request(OP_INSERT, CAPACITY, 32'sd7, 0);
    send_request(OP_GET, CAPACITY - 1, 32'sd0, 0);
    send_request(OP_GET, CAPACITY, 32'sd0, 0);
    send_request(OP_POP, 0, 32'sd0, 0);
    send_request(OP_PUSH, 0, $urandom, 0);
    // longest shifts in both directions
    send_request(OP_DELETE, 0, 32'sd0, 0);
    send_request(OP_INSERT, 0, $urandom, 0);
    send_request(OP_DELETE, CAPACITY - 1, 32'sd0, 0);
    send_request(OP_INSERT, CAPACITY - 1, $urandom, 0);
    send_request(OP_RANGE_DELETE, 1000, 32'sd0, 25);
    send_request(OP_RANGE_DELETE, 0, 32'sd0, CAPACITY);
  endtask

  task automatic run_random();
    int len;
    int r;
    int p;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      len = shadow_len;
      r   = $urandom_range(0, 99);
      if (r < 3)
        send_request(r[0] ? OP_SPARE_6 : OP_SPARE_7, $urandom_range(0, 2047), $urandom,
                     $urandom_range(0, 2047));
      else if (r < 10)
        send_request(OP_W'($urandom_range(0, 5)), $urandom_range(0, 2047), $urandom,
                     $urandom_range(0, 2047));
      else if (r < 35)
        send_request(len > SHRINK_ABOVE ? OP_POP : OP_PUSH, $urandom_range(0, 2047),
                     $urandom, $urandom_range(0, 2047));
      else if (r < 45)
        send_request(OP_POP, 0, $urandom, 0);
      else if (r < 65)
        send_request(len > SHRINK_ABOVE ? OP_DELETE : OP_INSERT, $urandom_range(0, len),
                     $urandom, 0);
      else if (r < 78)
        send_request(OP_DELETE, $urandom_range(0, len), $urandom, 0);
      else if (r < 92)
        send_request(OP_GET, $urandom_range(0, len), $urandom, 0);
      else begin
        // mostly legal ranges, with the odd one running one past the end
        p = $urandom_range(0, len);
        send_request(OP_RANGE_DELETE, p, $urandom, $urandom_range(0, len - p + 1));
      end
    end
  endtask

  initial begin
    int gap;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = draw_gap(rsp_calm);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("[positional_array_list_top] ERROR");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_PUSH;
    req.position  <= '0;
    req.value     <= '0;
    req.count     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_full_list();
    run_random();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("[positional_array_list_top] OK");
    else
      $display("[positional_array_list_top] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pal_pkg.sv
rtl/pal_req_if.sv
rtl/pal_rsp_if.sv
rtl/pal_datapath.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_top.sv
test/positional_array_list_checker.sv
test/positional_array_list_top_tb.sv
